[sv/pcf_pkg.sv]
`timescale 1ns / 1ps

package pcf_pkg;

  localparam int PALETTE_ENTRIES = 1024;
  localparam int ADDR_W          = $clog2(PALETTE_ENTRIES);
  localparam int WORD_W          = 16;
  localparam int IDX_W           = 10;
  localparam int SPEED_W         = 9;

  localparam logic [WORD_W-1:0] MASK_B = 16'h001F;
  localparam logic [WORD_W-1:0] MASK_G = 16'h03E0;
  localparam logic [WORD_W-1:0] MASK_R = 16'h7C00;

  // val = (UNIT - level) mod 2^16
  localparam logic [WORD_W-1:0] UNIT = 16'h0100;

  localparam logic [IDX_W-1:0] LOW_REGION_BASE = 10'h080;
  localparam logic [IDX_W-1:0] LOW_REGION_END  = 10'h100;
  localparam logic [IDX_W-1:0] HALF_END        = 10'h200;

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [WORD_W-1:0] word_t;

  typedef enum logic [1:0] {
    FUNC_START   = 2'd0,
    FUNC_CAPTURE = 2'd1,
    FUNC_RENDER  = 2'd2,
    FUNC_TICK    = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    CFG_COLOR     = 2'd0,
    CFG_SPEED     = 2'd1,
    CFG_REGION    = 2'd2,
    CFG_DIRECTION = 2'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    REGION_LOW  = 2'd0,
    REGION_HALF = 2'd1,
    REGION_ALL  = 2'd2,
    REGION_NONE = 2'd3
  } region_t;

  // Item state carried from the accept stage to the render stage
  typedef struct packed {
    logic  valid;
    logic  render;     // blend with the saved entry
    logic  fade_in;
    logic  in_region;
    logic  done;
    word_t word;       // final word when no blend is needed
    word_t val;
    word_t color;
  } stage_t;

  function automatic logic region_hit(input logic [1:0] kind,
                                      input logic [IDX_W-1:0] idx);
    logic hit;
    begin
      case (kind)
        REGION_LOW:  hit = (idx >= LOW_REGION_BASE) && (idx < LOW_REGION_END);
        REGION_HALF: hit = (idx < HALF_END);
        REGION_ALL:  hit = 1'b1;
        default:     hit = 1'b0;
      endcase
      return hit;
    end
  endfunction

  // ((a_f - b_f) * val / 256, toward zero) + base, masked to the field
  function automatic word_t blend_field(input word_t a, input word_t b,
                                        input word_t base, input word_t val,
                                        input word_t mask);
    logic signed [16:0] diff;
    logic signed [33:0] prod;
    logic signed [33:0] adj;
    logic signed [33:0] quot;
    word_t              sum;
    begin
      diff = $signed({1'b0, a & mask}) - $signed({1'b0, b & mask});
      prod = diff * $signed({1'b0, val});
      adj  = prod[33] ? (prod + 34'sd255) : prod;
      quot = adj >>> 8;
      sum  = quot[15:0] + base;
      return sum & mask;
    end
  endfunction

endpackage

[sv/palette_color_fade.sv]
`timescale 1ns / 1ps

// Palette fade engine. One command beat is taken on every cycle: busy never
// rises, so start may stay high back to back for a whole palette stream.
// Each command gives exactly one result beat, shown on out_* with out_strobe
// high for a single cycle: the strobe rises at the edge after the accepting
// one. There is no backpressure, so the receiver must take every beat as
// it comes. The result path runs through the saved-palette RAM (registered
// read, one write and one read port), loaded alongside the item register,
// and then through the blend stage and its output register. Level, done
// flag and register values are sampled at accept, so a tick or start right
// behind a render does not disturb it. Config writes are always ready
// (cfg_ready tied high) and take effect on the next command. Saved entries
// hold no value until captured.

module palette_color_fade (
  input  logic       clk,
  input  logic       rst_n,

  input  logic       start,
  output logic       busy,
  input  logic [1:0] in_func,
  input  logic [9:0] in_entry_index,
  input  logic [15:0] in_entry_value,

  output logic       out_strobe,
  output logic [15:0] out_palette_word,
  output logic       out_in_region,
  output logic       out_fade_done,

  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [15:0] cfg_data
);

  // ---------------- configuration registers ----------------
  pcf_pkg::word_t                  fade_color_r;
  logic [pcf_pkg::SPEED_W-1:0]     fade_speed_r;
  logic [1:0]                      region_kind_r;
  logic                            fade_dir_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fade_color_r  <= '0;
      fade_speed_r  <= 9'd16;
      region_kind_r <= pcf_pkg::REGION_ALL;
      fade_dir_r    <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        pcf_pkg::CFG_COLOR:     fade_color_r  <= cfg_data;
        pcf_pkg::CFG_SPEED:     fade_speed_r  <= cfg_data[pcf_pkg::SPEED_W-1:0];
        pcf_pkg::CFG_REGION:    region_kind_r <= cfg_data[1:0];
        pcf_pkg::CFG_DIRECTION: fade_dir_r    <= cfg_data[0];
        default:                ;
      endcase
    end
  end

  // ---------------- accept stage ----------------
  logic            accept;
  logic            hit;
  pcf_pkg::func_t  func;
  pcf_pkg::word_t  val;

  pcf_pkg::word_t  fade_level_r;
  pcf_pkg::word_t  fade_level_nxt;
  logic            done_flag_r;
  logic            done_flag_nxt;

  pcf_pkg::stage_t stage_r;
  pcf_pkg::stage_t stage_nxt;

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign func   = pcf_pkg::func_t'(in_func);
  assign hit    = pcf_pkg::region_hit(region_kind_r, in_entry_index);
  assign val    = pcf_pkg::UNIT - fade_level_r;

  always_comb begin
    fade_level_nxt    = fade_level_r;
    done_flag_nxt     = done_flag_r;

    stage_nxt.valid     = accept;
    stage_nxt.render    = 1'b0;
    stage_nxt.fade_in   = fade_dir_r;
    stage_nxt.in_region = 1'b0;
    stage_nxt.done      = done_flag_r;
    stage_nxt.word      = '0;
    stage_nxt.val       = val;
    stage_nxt.color     = fade_color_r;

    case (func)
      pcf_pkg::FUNC_START: begin
        fade_level_nxt = '0;
        done_flag_nxt  = 1'b0;
        stage_nxt.done = 1'b0;
      end
      pcf_pkg::FUNC_TICK: begin
        fade_level_nxt = fade_level_r
                       + {{(pcf_pkg::WORD_W - pcf_pkg::SPEED_W){1'b0}}, fade_speed_r};
        if (val == '0) begin
          done_flag_nxt = 1'b1;
        end
        stage_nxt.done = (val == '0);
      end
      pcf_pkg::FUNC_CAPTURE: begin
        stage_nxt.in_region = hit;
        if (!hit || !fade_dir_r) begin
          stage_nxt.word = in_entry_value;
        end
      end
      pcf_pkg::FUNC_RENDER: begin
        stage_nxt.in_region = hit;
        stage_nxt.render    = hit;
        stage_nxt.word      = in_entry_value;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fade_level_r  <= '0;
      done_flag_r   <= 1'b0;
      stage_r.valid <= 1'b0;
    end else begin
      if (accept) begin
        fade_level_r <= fade_level_nxt;
        done_flag_r  <= done_flag_nxt;
      end
      stage_r.valid <= stage_nxt.valid;
    end
    stage_r.render    <= stage_nxt.render;
    stage_r.fade_in   <= stage_nxt.fade_in;
    stage_r.in_region <= stage_nxt.in_region;
    stage_r.done      <= stage_nxt.done;
    stage_r.word      <= stage_nxt.word;
    stage_r.val       <= stage_nxt.val;
    stage_r.color     <= stage_nxt.color;
  end

  // ---------------- saved palette ----------------
  // Write and read both happen at the accepting edge; a capture followed by
  // a render of the same entry sees the new word since the write landed at an
  // earlier edge.
  logic            ram_we;
  pcf_pkg::addr_t  ram_addr;
  pcf_pkg::word_t  saved;

  assign ram_we   = accept && (func == pcf_pkg::FUNC_CAPTURE) && hit;
  assign ram_addr = pcf_pkg::addr_t'(in_entry_index);

  pcf_ram #(
    .WIDTH (pcf_pkg::WORD_W),
    .DEPTH (pcf_pkg::PALETTE_ENTRIES)
  ) u_saved (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_addr),
    .wdata (in_entry_value),
    .raddr (ram_addr),
    .rdata (saved)
  );

  // ---------------- blend stage and result register ----------------
  pcf_render u_render (
    .clk       (clk),
    .rst_n     (rst_n),
    .stage     (stage_r),
    .saved     (saved),
    .strobe    (out_strobe),
    .word      (out_palette_word),
    .in_region (out_in_region),
    .done      (out_fade_done)
  );

endmodule

[sv/pcf_ram.sv]
`timescale 1ns / 1ps

module pcf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[sv/pcf_render.sv]
`timescale 1ns / 1ps

module pcf_render (
  input  logic                  clk,
  input  logic                  rst_n,
  input  pcf_pkg::stage_t       stage,
  input  pcf_pkg::word_t        saved,
  output logic                  strobe,
  output pcf_pkg::word_t        word,
  output logic                  in_region,
  output logic                  done
);

  pcf_pkg::word_t a_w;
  pcf_pkg::word_t b_w;
  pcf_pkg::word_t blend_w;
  pcf_pkg::word_t word_nxt;

  logic           strobe_r;
  pcf_pkg::word_t word_r;
  logic           in_region_r;
  logic           done_r;

  // fade out: saved toward color, based on color; fade in: reversed
  assign a_w = stage.fade_in ? stage.color : saved;
  assign b_w = stage.fade_in ? saved : stage.color;

  assign blend_w = pcf_pkg::blend_field(a_w, b_w, b_w, stage.val, pcf_pkg::MASK_B)
                 | pcf_pkg::blend_field(a_w, b_w, b_w, stage.val, pcf_pkg::MASK_G)
                 | pcf_pkg::blend_field(a_w, b_w, b_w, stage.val, pcf_pkg::MASK_R);

  always_comb begin
    if (!stage.render) begin
      word_nxt = stage.word;
    end else if (stage.fade_in && (stage.val == '0)) begin
      word_nxt = saved;       // whole word, bit 15 kept
    end else begin
      word_nxt = blend_w;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= stage.valid;
    end
    word_r      <= word_nxt;
    in_region_r <= stage.in_region;
    done_r      <= stage.done;
  end

  assign strobe    = strobe_r;
  assign word      = word_r;
  assign in_region = in_region_r;
  assign done      = done_r;

endmodule
